@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PCALL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// The condition must never be true outside reset.
`define PCALL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ rtl/pcall_pkg.sv @@
`timescale 1ns / 1ps

package pcall_pkg;

  // CPU bookkeeping sizes
  localparam int MAX_CPUS = 8;
  localparam int IDX_W    = 3;   // start_index field width
  localparam int CNT_W    = 4;   // cpu_count register width
  localparam logic [CNT_W-1:0] CNT_RST = CNT_W'(MAX_CPUS);
  localparam logic [MAX_CPUS-1:0] ONLINE_RST = MAX_CPUS'(1);

  // Standard function identifiers (64-bit calling convention for the 0xC4 ids, 32-bit for the 0x84 ids)
  localparam logic [31:0] FN_VERSION      = 32'h8400_0000;
  localparam logic [31:0] FN_SUSPEND64    = 32'hC400_0001;
  localparam logic [31:0] FN_OFF          = 32'h8400_0002;
  localparam logic [31:0] FN_ON64         = 32'hC400_0003;
  localparam logic [31:0] FN_AFFINITY64   = 32'hC400_0004;
  localparam logic [31:0] FN_MIGRATE_TYPE = 32'h8400_0006;
  localparam logic [31:0] FN_SYS_OFF      = 32'h8400_0008;
  localparam logic [31:0] FN_SYS_RESET    = 32'h8400_0009;
  localparam logic [31:0] FN_FEATURES     = 32'h8400_000A;

  // Returned values
  localparam logic [16:0] RV_VERSION_1_1  = 17'h1_0001;
  localparam logic [16:0] RV_MIGRATE_NONE = 17'd2;
  localparam logic [7:0]  TARGET_MASK     = 8'hFF;

  typedef enum logic [2:0] {
    ST_SUCCESS  = 3'd0,
    ST_NOT_SUPP = 3'd1,
    ST_INVALID  = 3'd2,
    ST_ALREADY  = 3'd3,
    ST_VALUE    = 3'd4
  } status_t;

  // One incoming call
  typedef struct packed {
    logic [31:0] func;
    logic [63:0] first_arg;
    logic [63:0] entry_address;
  } item_t;

  // Architectural state
  typedef struct packed {
    logic [MAX_CPUS-1:0] online;
    logic                off_flag;
    logic                reset_flag;
  } cpu_state_t;

  // One answer
  typedef struct packed {
    status_t          status;
    logic [16:0]      ret_value;
    logic             start_cpu;
    logic [IDX_W-1:0] start_index;
    logic [63:0]      start_address;
    logic             powered_off;
    logic             reset_requested;
  } result_t;

endpackage

@@ rtl/pcall_exec.sv @@
`timescale 1ns / 1ps

module pcall_exec (
  input  pcall_pkg::item_t                 item,
  input  pcall_pkg::cpu_state_t            state,
  input  logic [pcall_pkg::CNT_W-1:0]      cpu_count,
  output pcall_pkg::result_t               result,
  output pcall_pkg::cpu_state_t            state_nxt
);
  import pcall_pkg::*;

  logic [CNT_W-1:0] live_cnt;
  logic [7:0]       target;
  logic             tgt_bad;
  logic             tgt_on;
  logic             feat_known;
  logic             off_found;

  // Clamp the count to the number of bookkept CPUs
  assign live_cnt = (cpu_count > CNT_W'(MAX_CPUS)) ? CNT_W'(MAX_CPUS) : cpu_count;
  assign target   = item.first_arg[7:0] & TARGET_MASK;
  assign tgt_bad  = (target >= 8'(live_cnt));
  assign tgt_on   = state.online[target[IDX_W-1:0]];

  // FEATURES compares the whole 64-bit argument
  assign feat_known = (item.first_arg == 64'(FN_VERSION))      ||
                      (item.first_arg == 64'(FN_ON64))         ||
                      (item.first_arg == 64'(FN_OFF))          ||
                      (item.first_arg == 64'(FN_AFFINITY64))   ||
                      (item.first_arg == 64'(FN_MIGRATE_TYPE)) ||
                      (item.first_arg == 64'(FN_SYS_OFF))      ||
                      (item.first_arg == 64'(FN_SYS_RESET));

  // Call decode and state update
  always_comb begin
    state_nxt            = state;
    result.status        = ST_SUCCESS;
    result.ret_value     = '0;
    result.start_cpu     = 1'b0;
    result.start_index   = '0;
    result.start_address = '0;
    off_found            = 1'b0;

    case (item.func)
      FN_VERSION: begin
        result.status    = ST_VALUE;
        result.ret_value = RV_VERSION_1_1;
      end
      FN_ON64: begin
        if (tgt_bad) begin
          result.status = ST_INVALID;
        end else if (tgt_on) begin
          result.status = ST_ALREADY;
        end else begin
          state_nxt.online[target[IDX_W-1:0]] = 1'b1;
          result.start_cpu     = 1'b1;
          result.start_index   = target[IDX_W-1:0];
          result.start_address = item.entry_address;
        end
      end
      FN_OFF: begin
        // lowest online CPU above 0, below the live count
        for (int i = 1; i < MAX_CPUS; i++) begin
          if (!off_found && state.online[i] && (CNT_W'(i) < live_cnt)) begin
            state_nxt.online[i] = 1'b0;
            off_found           = 1'b1;
          end
        end
      end
      FN_AFFINITY64: begin
        if (tgt_bad) begin
          result.status = ST_INVALID;
        end else begin
          result.status    = ST_VALUE;
          result.ret_value = 17'(tgt_on);
        end
      end
      FN_MIGRATE_TYPE: begin
        result.status    = ST_VALUE;
        result.ret_value = RV_MIGRATE_NONE;
      end
      FN_SYS_OFF:   state_nxt.off_flag   = 1'b1;
      FN_SYS_RESET: state_nxt.reset_flag = 1'b1;
      FN_FEATURES: begin
        result.status = feat_known ? ST_SUCCESS : ST_NOT_SUPP;
      end
      FN_SUSPEND64: result.status = ST_SUCCESS;
      default:      result.status = ST_NOT_SUPP;
    endcase

    result.powered_off     = state_nxt.off_flag;
    result.reset_requested = state_nxt.reset_flag;
  end

endmodule

@@ rtl/cpu_power_call_handler.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Power-management call handler: one call in, one answer out, at a sustained
// rate of one item per clock while out_ready holds high. An accepted call
// lands in an input register; once the output slot is free, the single-pass
// decode against the CPU online bits produces the answer into the output
// register, which drives the out_ ports. A stalled answer (out_ready low) with
// a call already waiting in the input register drops in_ready until the answer
// leaves. The state read by one call is the state written by the call before
// it, committed in the same edge that loads the answer.
// cpu_count is written through cfg_wr_en/cfg_wr_data and resets to 8.
module cpu_power_call_handler (
  input  logic                          clk,
  input  logic                          rst_n,
  // call channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   in_func,
  input  logic [63:0]                   in_first_arg,
  input  logic [63:0]                   in_entry_address,
  // answer channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [16:0]                   out_ret_value,
  output logic                          out_start_cpu,
  output logic [pcall_pkg::IDX_W-1:0]   out_start_index,
  output logic [63:0]                   out_start_address,
  output logic                          out_powered_off,
  output logic                          out_reset_requested,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [pcall_pkg::CNT_W-1:0]   cfg_wr_data
);
  import pcall_pkg::*;

  logic             in_vld_r;
  item_t            item_r;
  logic             out_vld_r;
  result_t          res_r;
  cpu_state_t       state_r;
  logic [CNT_W-1:0] cpu_count_r;

  result_t          result;
  cpu_state_t       state_nxt;
  logic             adv;

  // Decode stage
  pcall_exec u_exec (
    .item      (item_r),
    .state     (state_r),
    .cpu_count (cpu_count_r),
    .result    (result),
    .state_nxt (state_nxt)
  );

  // Handshake: move an item forward when the output slot frees
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      state_r     <= '{online: ONLINE_RST, off_flag: 1'b0, reset_flag: 1'b0};
      cpu_count_r <= CNT_RST;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        cpu_count_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{func: in_func, first_arg: in_first_arg,
                  entry_address: in_entry_address};
    end
    if (adv) begin
      res_r <= result;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_status          = res_r.status;
  assign out_ret_value       = res_r.ret_value;
  assign out_start_cpu       = res_r.start_cpu;
  assign out_start_index     = res_r.start_index;
  assign out_start_address   = res_r.start_address;
  assign out_powered_off     = res_r.powered_off;
  assign out_reset_requested = res_r.reset_requested;

  // Checks
  `PCALL_NEVER(a_cpu0_online, !state_r.online[0], "CPU 0 went offline")
  `PCALL_ASSERT(a_off_sticky, state_r.off_flag |=> state_r.off_flag, "off flag cleared")
  `PCALL_ASSERT(a_rst_sticky, state_r.reset_flag |=> state_r.reset_flag, "reset flag cleared")
  `PCALL_NEVER(a_start_status, out_vld_r && res_r.start_cpu && (res_r.status != ST_SUCCESS),
               "start request without success")
  `PCALL_ASSERT(a_hold_item, (in_vld_r && !adv) |=> in_vld_r, "stalled item dropped")

endmodule
